>>> rtl/csv_decimal_field_parser_defines.svh
// Assertion macros shared by the CSV decimal field parser RTL.
`ifndef CSV_DECIMAL_FIELD_PARSER_DEFINES_SVH
`define CSV_DECIMAL_FIELD_PARSER_DEFINES_SVH

// Condition that must hold on every cycle out of reset.
`define CDFP_CHECK(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Condition that, once true, forces a consequence on the next cycle.
`define CDFP_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cdfp_pkg.sv
// Package with character codes, parse phase codes and register map of the field parser.
`timescale 1ns / 1ps
package cdfp_pkg;

    typedef logic [7:0] t_char;
    typedef logic [1:0] t_phase;

    localparam t_phase PH_BLANKS  = 2'd0;
    localparam t_phase PH_DIGITS  = 2'd1;
    localparam t_phase PH_DONE    = 2'd2;
    localparam t_phase PH_DISCARD = 2'd3;

    localparam t_char CHR_NUL   = 8'd0;
    localparam t_char CHR_TAB   = 8'd9;
    localparam t_char CHR_CR    = 8'd13;
    localparam t_char CHR_SPACE = 8'd32;
    localparam t_char CHR_PLUS  = 8'd43;
    localparam t_char CHR_COMMA = 8'd44;
    localparam t_char CHR_MINUS = 8'd45;
    localparam t_char CHR_ZERO  = 8'd48;
    localparam t_char CHR_NINE  = 8'd57;

    localparam int   ADDR_W         = 3;
    localparam logic REG_MAX_FIELDS = 1'b0;
    localparam logic [7:0] MAX_FIELDS_RST = 8'd16;

endpackage

>>> rtl/csv_decimal_field_parser.sv
// Streaming comma-separated decimal field parser: one character per beat in, one value per field out.
`timescale 1ns / 1ps
// Takes one byte of a NUL-terminated string per beat and returns one signed 32-bit value per
// comma-separated field, read like atoi (blanks, optional sign, digits, wrap modulo 2^32), with
// its field index and a last flag. Throughput is one character per cycle while o_stall is low; a
// character is held in an input register, and the value of the field that a comma or NUL ends
// is registered from it in the result register. o_stall rises only when the held character
// ends a field while the result register is full and the output side is stalling. Characters
// that end no field keep flowing even then. max_fields (APB, address 0) caps the values per
// string; after the cap the string is dropped up to its NUL. Only the first SCRATCH_BYTES-1
// characters of a field are parsed.
`include "csv_decimal_field_parser_defines.svh"
module csv_decimal_field_parser #(
    parameter int SCRATCH_BYTES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  cdfp_pkg::t_char             i_char_code,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_field_value,
    output logic [7:0]                  o_field_index,
    output logic                        o_last_field,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cdfp_pkg::*;

    localparam int LEN_W = $clog2(SCRATCH_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(SCRATCH_BYTES - 1);

    logic [7:0]       r_max;
    t_char            r_char;
    logic             r_in_vld;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [31:0]      r_acc, n_acc;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_fields, n_fields;
    logic             r_out_vld;
    logic [31:0]      r_val;
    logic [7:0]       r_idx;
    logic             r_last;

    logic        w_nul, w_end, w_blank, w_digit, w_emit, w_last, w_adv, w_out_free;
    logic [31:0] w_acc10, w_value;
    logic [8:0]  w_next_cnt;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_FIELDS) ? {24'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_FIELDS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_FIELDS) begin
            r_max <= pwdata[7:0];
        end
    end

    // Character decode and field state update
    assign w_nul      = (r_char == CHR_NUL);
    assign w_end      = w_nul || (r_char == CHR_COMMA);
    assign w_blank    = (r_char == CHR_SPACE) || (r_char >= CHR_TAB && r_char <= CHR_CR);
    assign w_digit    = (r_char >= CHR_ZERO) && (r_char <= CHR_NINE);
    assign w_acc10    = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                        + {28'd0, 4'(r_char - CHR_ZERO)};
    assign w_value    = r_neg ? (32'd0 - r_acc) : r_acc;
    assign w_next_cnt = {1'b0, r_fields} + 9'd1;
    assign w_last     = w_nul || (w_next_cnt >= {1'b0, r_max});
    assign w_emit     = (r_phase != PH_DISCARD) && w_end && (r_max != 8'd0);

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_adv      = r_in_vld && (!w_emit || w_out_free);
    assign o_stall    = r_in_vld && !w_adv;

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_len    = r_len;
        n_fields = r_fields;
        if (r_phase == PH_DISCARD) begin
            if (w_nul) begin
                n_fields = 8'd0;
                n_phase  = PH_BLANKS;
                n_neg    = 1'b0;
                n_acc    = 32'd0;
                n_len    = '0;
            end
        end else if (!w_end) begin
            if (r_len != LEN_LIMIT) begin
                n_len = r_len + LEN_W'(1);
                if (r_phase == PH_BLANKS) begin
                    priority if (w_blank) begin
                        n_phase = PH_BLANKS;
                    end else if (r_char == CHR_MINUS || r_char == CHR_PLUS) begin
                        n_neg   = (r_char == CHR_MINUS);
                        n_phase = PH_DIGITS;
                    end else if (w_digit) begin
                        n_acc   = w_acc10;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end else if (r_phase == PH_DIGITS) begin
                    if (w_digit) begin
                        n_acc = w_acc10;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
        end else begin
            // field ends: clear it, then pick the next phase from the string end and the cap
            n_neg = 1'b0;
            n_acc = 32'd0;
            n_len = '0;
            if (w_nul) begin
                n_fields = 8'd0;
                n_phase  = PH_BLANKS;
            end else if (r_max == 8'd0) begin
                n_phase = PH_DISCARD;
            end else begin
                n_fields = w_next_cnt[7:0];
                n_phase  = w_last ? PH_DISCARD : PH_BLANKS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_BLANKS;
            r_neg     <= 1'b0;
            r_acc     <= 32'd0;
            r_len     <= '0;
            r_fields  <= 8'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_phase  <= n_phase;
                r_neg    <= n_neg;
                r_acc    <= n_acc;
                r_len    <= n_len;
                r_fields <= n_fields;
            end
            if (w_adv && w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_char <= i_char_code;
        end
        if (w_adv && w_emit) begin
            r_val  <= w_value;
            r_idx  <= r_fields;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_field_value = r_val;
    assign o_field_index = r_idx;
    assign o_last_field  = r_last;

    `CDFP_CHECK(a_stall_needs_full_out, !o_stall || (r_out_vld && i_stall && w_emit), "input stalled without a blocked result")
    `CDFP_CHECK(a_no_emit_in_discard, !(w_emit && r_phase == PH_DISCARD), "value emitted while discarding")
    `CDFP_NEXT(a_nul_restarts, w_adv && w_nul, r_fields == 8'd0 && r_phase == PH_BLANKS && r_acc == 32'd0, "NUL did not restart the string")
    `CDFP_NEXT(a_last_discards, w_adv && w_emit && w_last && !w_nul, r_phase == PH_DISCARD, "field cap did not start discarding")

endmodule
